>>> rtl/mcfir_pkg.sv
// Shared widths, command codes and control structs for the MIMO complex FIR channel.
package mcfir_pkg;

    // Default array geometry
    localparam int NUM_TX_DEF = 2;
    localparam int NUM_RX_DEF = 2;
    localparam int TAPS_DEF   = 8;

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int DATA_W  = 16;
    localparam int CPLX_W  = 2 * DATA_W;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int GAIN_W  = 16;
    localparam int TAPS_SEL_W = 3;

    // Gain scaling: accumulator split point, shift of Q2.30 sums times gain to Q1.15
    localparam int ACC_LO_W   = 24;
    localparam int FRAC_SHIFT = 30;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;
    localparam logic [DATA_W-1:0] SAT_MAX    = 16'h7fff;
    localparam logic [DATA_W-1:0] SAT_MIN    = 16'h8000;

    // Input beat function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic tap_load;   // write the tap on the input beat
        logic hist_push;  // shift the sample vector into the history
        logic hist_clr;   // empty the history
        logic rd_en;      // issue one multiply-accumulate term
        logic first;      // term opens a receive sum
        logic last;       // term closes a receive sum
        logic load_out;   // move the finished result into the output register
        logic out_last;   // result belongs to the final receive antenna
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic res_done;   // scaled result ready this cycle
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

>>> rtl/mcfir_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mcfir_ctrl.sv
// Sequencer: decodes input beats and walks receive, transmit and delay loops.
module mcfir_ctrl #(
    parameter int NUM_TX = mcfir_pkg::NUM_TX_DEF,
    parameter int NUM_RX = mcfir_pkg::NUM_RX_DEF,
    parameter int TAPS   = mcfir_pkg::TAPS_DEF,
    localparam int TX_W  = (NUM_TX > 1) ? $clog2(NUM_TX) : 1,
    localparam int RX_W  = (NUM_RX > 1) ? $clog2(NUM_RX) : 1,
    localparam int L_W   = (TAPS > 1) ? $clog2(TAPS) : 1,
    localparam int TAP_DEPTH = NUM_RX * NUM_TX * TAPS,
    localparam int TA_W  = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [mcfir_pkg::FUNC_W-1:0] i_func,
    input  mcfir_pkg::t_sts             i_sts,
    output mcfir_pkg::t_cmd             o_cmd,
    output logic [RX_W-1:0]             o_cmd_rx,
    output logic [TX_W-1:0]             o_cmd_tx,
    output logic [L_W-1:0]              o_cmd_l,
    output logic [TA_W-1:0]             o_cmd_ta
);

    import mcfir_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state          r_state;
    logic [RX_W-1:0] r_rx;
    logic [TX_W-1:0] r_tx;
    logic [L_W-1:0]  r_l;
    logic [TA_W-1:0] r_ta;

    logic w_accept;
    logic w_tx_end;
    logic w_l_end;
    logic w_rx_end;
    logic w_emit;

    always_comb begin
        w_accept = i_in_valid && (r_state == S_IDLE);
        w_tx_end = (r_tx == TX_W'(NUM_TX - 1));
        w_l_end  = (r_l == L_W'(TAPS - 1));
        w_rx_end = (r_rx == RX_W'(NUM_RX - 1));
        w_emit   = ((r_state == S_WAIT && i_sts.res_done) || r_state == S_EMIT)
                   && i_sts.out_free;

        o_cmd.tap_load  = w_accept && (i_func == FUNC_LOAD);
        o_cmd.hist_push = w_accept && (i_func == FUNC_SAMPLE);
        o_cmd.hist_clr  = w_accept && (i_func == FUNC_CLEAR);
        o_cmd.rd_en     = (r_state == S_RUN);
        o_cmd.first     = (r_tx == '0) && (r_l == '0);
        o_cmd.last      = w_tx_end && w_l_end;
        o_cmd.load_out  = w_emit;
        o_cmd.out_last  = w_rx_end;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd_rx   = r_rx;
    assign o_cmd_tx   = r_tx;
    assign o_cmd_l    = r_l;
    assign o_cmd_ta   = r_ta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rx    <= '0;
            r_tx    <= '0;
            r_l     <= '0;
            r_ta    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_func == FUNC_SAMPLE) begin
                        r_state <= S_RUN;
                        r_rx    <= '0;
                        r_tx    <= '0;
                        r_l     <= '0;
                        r_ta    <= '0;
                    end
                end
                S_RUN: begin
                    r_ta <= r_ta + TA_W'(1);
                    if (w_l_end) begin
                        r_l <= '0;
                        if (w_tx_end) begin
                            r_tx    <= '0;
                            r_state <= S_WAIT;
                        end else begin
                            r_tx <= r_tx + TX_W'(1);
                        end
                    end else begin
                        r_l <= r_l + L_W'(1);
                    end
                end
                S_WAIT, S_EMIT: begin
                    if (w_emit) begin
                        if (w_rx_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rx    <= r_rx + RX_W'(1);
                            r_state <= S_RUN;
                        end
                    end else if (r_state == S_WAIT && i_sts.res_done) begin
                        r_state <= S_EMIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/mcfir_dp.sv
// Datapath: tap and history stores, complex MAC pipeline, gain scaling, output register.
module mcfir_dp #(
    parameter int NUM_TX = mcfir_pkg::NUM_TX_DEF,
    parameter int NUM_RX = mcfir_pkg::NUM_RX_DEF,
    parameter int TAPS   = mcfir_pkg::TAPS_DEF,
    localparam int TX_W  = (NUM_TX > 1) ? $clog2(NUM_TX) : 1,
    localparam int RX_W  = (NUM_RX > 1) ? $clog2(NUM_RX) : 1,
    localparam int L_W   = (TAPS > 1) ? $clog2(TAPS) : 1,
    localparam int TAP_DEPTH = NUM_RX * NUM_TX * TAPS,
    localparam int TA_W  = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mcfir_pkg::t_cmd                    i_cmd,
    input  logic [RX_W-1:0]                    i_cmd_rx,
    input  logic [TX_W-1:0]                    i_cmd_tx,
    input  logic [L_W-1:0]                     i_cmd_l,
    input  logic [TA_W-1:0]                    i_cmd_ta,
    output mcfir_pkg::t_sts                    o_sts,
    input  logic                               i_cfg_we,
    input  logic [mcfir_pkg::GAIN_W-1:0]       i_cfg_wdata,
    input  logic                               i_rx_sel,
    input  logic                               i_tx_sel,
    input  logic [mcfir_pkg::TAPS_SEL_W-1:0]   i_tap_sel,
    input  logic signed [mcfir_pkg::DATA_W-1:0] i_tap_re,
    input  logic signed [mcfir_pkg::DATA_W-1:0] i_tap_im,
    input  logic signed [mcfir_pkg::DATA_W-1:0] i_samp0_re,
    input  logic signed [mcfir_pkg::DATA_W-1:0] i_samp0_im,
    input  logic signed [mcfir_pkg::DATA_W-1:0] i_samp1_re,
    input  logic signed [mcfir_pkg::DATA_W-1:0] i_samp1_im,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_rx_index,
    output logic signed [mcfir_pkg::DATA_W-1:0] o_out_re,
    output logic signed [mcfir_pkg::DATA_W-1:0] o_out_im,
    output logic                               o_last
);

    import mcfir_pkg::*;

    localparam int TERMS = NUM_TX * TAPS;
    localparam int CNT_W = $clog2(TAPS + 1);
    localparam int ACC_W = PROD_W + 1 + $clog2(TERMS);
    localparam int HI_W  = ACC_W - ACC_LO_W;
    localparam int PL_W  = ACC_LO_W + GAIN_W;
    localparam int PH_W  = HI_W + GAIN_W + 1;
    localparam int SUM_W = ACC_W + GAIN_W + 1;
    localparam int Q_W   = SUM_W - FRAC_SHIFT;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (FRAC_SHIFT - 1);

    // Path gain register
    logic [GAIN_W-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    // Tap store
    logic              w_tap_ok;
    logic [TA_W-1:0]   w_tap_waddr;
    logic [CPLX_W-1:0] w_tap_rdata;

    assign w_tap_ok = (int'(i_rx_sel) < NUM_RX) && (int'(i_tx_sel) < NUM_TX)
                      && (int'(i_tap_sel) < TAPS);
    assign w_tap_waddr = TA_W'((int'(i_rx_sel) * NUM_TX + int'(i_tx_sel)) * TAPS
                               + int'(i_tap_sel));

    mcfir_ram #(
        .WIDTH (CPLX_W),
        .DEPTH (TAP_DEPTH)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tap_load && w_tap_ok),
        .i_waddr (w_tap_waddr),
        .i_wdata ({i_tap_re, i_tap_im}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd_ta),
        .o_rdata (w_tap_rdata)
    );

    // Sample history: one circular buffer per transmit antenna, a fill count
    // marks how many delays hold real samples since the last clear
    logic [L_W-1:0]    r_wp;
    logic [L_W-1:0]    n_wp;
    logic [CNT_W-1:0]  r_cnt;
    logic [L_W-1:0]    w_haddr;
    logic              w_hist_ok;
    logic [CPLX_W-1:0] w_hist_wdata [NUM_TX];
    logic [CPLX_W-1:0] w_hist_rdata [NUM_TX];

    assign n_wp      = (r_wp == L_W'(TAPS - 1)) ? '0 : r_wp + L_W'(1);
    assign w_haddr   = (r_wp >= i_cmd_l) ? r_wp - i_cmd_l : r_wp + L_W'(TAPS) - i_cmd_l;
    assign w_hist_ok = (CNT_W'(i_cmd_l) < r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.hist_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.hist_push) begin
            r_wp <= n_wp;
            if (r_cnt != CNT_W'(TAPS)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    for (genvar g = 0; g < NUM_TX; g++) begin : g_hist
        if (g == 0) begin : g_a0
            assign w_hist_wdata[g] = {i_samp0_re, i_samp0_im};
        end else if (g == 1) begin : g_a1
            assign w_hist_wdata[g] = {i_samp1_re, i_samp1_im};
        end else begin : g_zero
            assign w_hist_wdata[g] = '0;
        end

        mcfir_ram #(
            .WIDTH (CPLX_W),
            .DEPTH (TAPS)
        ) u_hist_ram (
            .i_clk   (i_clk),
            .i_we    (i_cmd.hist_push),
            .i_waddr (n_wp),
            .i_wdata (w_hist_wdata[g]),
            .i_re    (i_cmd.rd_en),
            .i_raddr (w_haddr),
            .o_rdata (w_hist_rdata[g])
        );
    end

    // Stage 1: term tags alongside the store reads
    logic            r_s1_v;
    logic            r_s1_first;
    logic            r_s1_last;
    logic            r_s1_ok;
    logic [TX_W-1:0] r_s1_tx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.rd_en;
        end
        r_s1_first <= i_cmd.first;
        r_s1_last  <= i_cmd.last;
        r_s1_ok    <= w_hist_ok;
        r_s1_tx    <= i_cmd_tx;
    end

    // Stage 2: four real products of one complex multiply
    logic signed [DATA_W-1:0] w_tr;
    logic signed [DATA_W-1:0] w_ti;
    logic signed [DATA_W-1:0] w_sr;
    logic signed [DATA_W-1:0] w_si;
    logic [CPLX_W-1:0]        w_smp;
    logic signed [PROD_W-1:0] r_p_rr;
    logic signed [PROD_W-1:0] r_p_ii;
    logic signed [PROD_W-1:0] r_p_ri;
    logic signed [PROD_W-1:0] r_p_ir;
    logic                     r_s2_v;
    logic                     r_s2_first;
    logic                     r_s2_last;

    assign w_smp = r_s1_ok ? w_hist_rdata[r_s1_tx] : '0;
    assign w_tr  = $signed(w_tap_rdata[CPLX_W-1:DATA_W]);
    assign w_ti  = $signed(w_tap_rdata[DATA_W-1:0]);
    assign w_sr  = $signed(w_smp[CPLX_W-1:DATA_W]);
    assign w_si  = $signed(w_smp[DATA_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_p_rr     <= w_tr * w_sr;
        r_p_ii     <= w_ti * w_si;
        r_p_ri     <= w_tr * w_si;
        r_p_ir     <= w_ti * w_sr;
    end

    // Stage 3: accumulate; lane 0 is real, lane 1 imaginary
    logic signed [PROD_W:0]  w_term [2];
    logic signed [ACC_W-1:0] r_acc  [2];
    logic                    r_s3_v;

    assign w_term[0] = (PROD_W + 1)'(r_p_rr) - (PROD_W + 1)'(r_p_ii);
    assign w_term[1] = (PROD_W + 1)'(r_p_ri) + (PROD_W + 1)'(r_p_ir);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v && r_s2_last;
        end
        for (int k = 0; k < 2; k++) begin
            if (r_s2_v) begin
                if (r_s2_first) begin
                    r_acc[k] <= ACC_W'(w_term[k]);
                end else begin
                    r_acc[k] <= r_acc[k] + ACC_W'(w_term[k]);
                end
            end
        end
    end

    // Stage 4: gain multiply in two partial products
    logic [PL_W-1:0]        r_pl [2];
    logic signed [PH_W-1:0] r_ph [2];
    logic                   r_s4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
        for (int k = 0; k < 2; k++) begin
            if (r_s3_v) begin
                r_pl[k] <= PL_W'(r_acc[k][ACC_LO_W-1:0]) * PL_W'(r_gain);
                r_ph[k] <= $signed(r_acc[k][ACC_W-1:ACC_LO_W]) * $signed({1'b0, r_gain});
            end
        end
    end

    // Stage 5: recombine, round half up, saturate
    logic signed [SUM_W-1:0] w_sum [2];
    logic [Q_W-1:0]          w_q   [2];
    logic [DATA_W-1:0]       w_sat [2];
    logic [DATA_W-1:0]       r_res [2];
    logic                    r_res_v;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_sum[k] = (SUM_W'(r_ph[k]) <<< ACC_LO_W) + $signed(SUM_W'(r_pl[k])) + ROUND_BIAS;
            w_q[k]   = w_sum[k][SUM_W-1:FRAC_SHIFT];
            if (!w_q[k][Q_W-1] && (|w_q[k][Q_W-2:DATA_W-1])) begin
                w_sat[k] = SAT_MAX;
            end else if (w_q[k][Q_W-1] && !(&w_q[k][Q_W-2:DATA_W-1])) begin
                w_sat[k] = SAT_MIN;
            end else begin
                w_sat[k] = w_q[k][DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else begin
            r_res_v <= r_s4_v;
        end
        if (r_s4_v) begin
            r_res[0] <= w_sat[0];
            r_res[1] <= w_sat[1];
        end
    end

    // Output register
    logic              r_out_v;
    logic              r_out_rx;
    logic              r_out_last;
    logic [DATA_W-1:0] r_out_re;
    logic [DATA_W-1:0] r_out_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_rx   <= i_cmd_rx[0];
            r_out_last <= i_cmd.out_last;
            r_out_re   <= r_res[0];
            r_out_im   <= r_res[1];
        end
    end

    assign o_sts.res_done = r_res_v;
    assign o_sts.out_free = !r_out_v || i_out_ready;

    assign o_out_valid = r_out_v;
    assign o_rx_index  = r_out_rx;
    assign o_last      = r_out_last;
    assign o_out_re    = $signed(r_out_re);
    assign o_out_im    = $signed(r_out_im);

endmodule

>>> rtl/mimo_complex_fir_channel.sv
// Top level of the MIMO complex FIR channel: sequencer plus MAC datapath.
//
//   channel  direction  handshake                 payload
//   cfg      in         i_cfg_we (no wait)        i_cfg_wdata: path gain, Q1.15 unsigned
//   in       in         i_in_valid / o_in_ready   func, rx/tx/tap select, tap, two samples
//   out      out        o_out_valid / i_out_ready rx_index, out_re, out_im, last
//
// A tap load or history clear leaves the sequencer idle and ready. A sample
// beat holds it busy while the single shared complex multiply-accumulate
// visits every tap once per receive antenna, plus the read, multiply,
// accumulate, gain and saturate stages that drain before each result.
// A stalled output holds the sequencer before the next receive antenna.
// Reset is synchronous, active low: the history reads as empty, the gain
// returns to unity and taps stay unwritten.
module mimo_complex_fir_channel #(
    parameter int NUM_TX = mcfir_pkg::NUM_TX_DEF,
    parameter int NUM_RX = mcfir_pkg::NUM_RX_DEF,
    parameter int TAPS   = mcfir_pkg::TAPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [mcfir_pkg::GAIN_W-1:0]        i_cfg_wdata,
    // input beats
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mcfir_pkg::FUNC_W-1:0]        i_func,
    input  logic                                i_rx_sel,
    input  logic                                i_tx_sel,
    input  logic [mcfir_pkg::TAPS_SEL_W-1:0]    i_tap_sel,
    input  logic signed [mcfir_pkg::DATA_W-1:0] i_tap_re,
    input  logic signed [mcfir_pkg::DATA_W-1:0] i_tap_im,
    input  logic signed [mcfir_pkg::DATA_W-1:0] i_samp0_re,
    input  logic signed [mcfir_pkg::DATA_W-1:0] i_samp0_im,
    input  logic signed [mcfir_pkg::DATA_W-1:0] i_samp1_re,
    input  logic signed [mcfir_pkg::DATA_W-1:0] i_samp1_im,
    // result beats
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_rx_index,
    output logic signed [mcfir_pkg::DATA_W-1:0] o_out_re,
    output logic signed [mcfir_pkg::DATA_W-1:0] o_out_im,
    output logic                                o_last
);

    import mcfir_pkg::*;

    localparam int TX_W      = (NUM_TX > 1) ? $clog2(NUM_TX) : 1;
    localparam int RX_W      = (NUM_RX > 1) ? $clog2(NUM_RX) : 1;
    localparam int L_W       = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int TAP_DEPTH = NUM_RX * NUM_TX * TAPS;
    localparam int TA_W      = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;

    // Sequencer commands and datapath status
    t_cmd            w_cmd;
    t_sts            w_sts;
    logic [RX_W-1:0] w_cmd_rx;
    logic [TX_W-1:0] w_cmd_tx;
    logic [L_W-1:0]  w_cmd_l;
    logic [TA_W-1:0] w_cmd_ta;

    // Walk the receive, transmit and delay loops; take input beats only when idle
    mcfir_ctrl #(
        .NUM_TX (NUM_TX),
        .NUM_RX (NUM_RX),
        .TAPS   (TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_cmd_rx   (w_cmd_rx),
        .o_cmd_tx   (w_cmd_tx),
        .o_cmd_l    (w_cmd_l),
        .o_cmd_ta   (w_cmd_ta)
    );

    // Hold the stores, run the MAC pipeline and drive the result beat
    mcfir_dp #(
        .NUM_TX (NUM_TX),
        .NUM_RX (NUM_RX),
        .TAPS   (TAPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_rx    (w_cmd_rx),
        .i_cmd_tx    (w_cmd_tx),
        .i_cmd_l     (w_cmd_l),
        .i_cmd_ta    (w_cmd_ta),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx_sel    (i_rx_sel),
        .i_tx_sel    (i_tx_sel),
        .i_tap_sel   (i_tap_sel),
        .i_tap_re    (i_tap_re),
        .i_tap_im    (i_tap_im),
        .i_samp0_re  (i_samp0_re),
        .i_samp0_im  (i_samp0_im),
        .i_samp1_re  (i_samp1_re),
        .i_samp1_im  (i_samp1_im),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rx_index  (o_rx_index),
        .o_out_re    (o_out_re),
        .o_out_im    (o_out_im),
        .o_last      (o_last)
    );

endmodule

>>> sim/mimo_complex_fir_channel_tb.sv
// Self-checking testbench for the MIMO complex FIR channel: result ledger plus beat drivers.

typedef struct {
    logic [mcfir_pkg::FUNC_W-1:0]        func;
    logic                                rx_sel;
    logic                                tx_sel;
    logic [mcfir_pkg::TAPS_SEL_W-1:0]    tap_sel;
    logic signed [mcfir_pkg::DATA_W-1:0] tap_re;
    logic signed [mcfir_pkg::DATA_W-1:0] tap_im;
    logic signed [mcfir_pkg::DATA_W-1:0] samp0_re;
    logic signed [mcfir_pkg::DATA_W-1:0] samp0_im;
    logic signed [mcfir_pkg::DATA_W-1:0] samp1_re;
    logic signed [mcfir_pkg::DATA_W-1:0] samp1_im;
} chan_beat_t;

typedef struct {
    logic                                rx_index;
    logic signed [mcfir_pkg::DATA_W-1:0] out_re;
    logic signed [mcfir_pkg::DATA_W-1:0] out_im;
    logic                                last;
} rx_sample_t;

class rx_sample_ledger;
    localparam int NRX         = mcfir_pkg::NUM_RX_DEF;
    localparam int NTX         = mcfir_pkg::NUM_TX_DEF;
    localparam int NTAP        = mcfir_pkg::TAPS_DEF;
    localparam int MAX_REPORTS = 10;

    longint     tap_r[NRX*NTX*NTAP];
    longint     tap_i[NRX*NTX*NTAP];
    longint     hist_r[NTX*NTAP];
    longint     hist_i[NTX*NTAP];
    longint     gain;
    rx_sample_t pending[$];
    int         mismatches;

    function new();
        foreach (tap_r[i]) begin
            tap_r[i] = 0;
            tap_i[i] = 0;
        end
        foreach (hist_r[i]) begin
            hist_r[i] = 0;
            hist_i[i] = 0;
        end
        gain       = longint'(mcfir_pkg::GAIN_RESET);
        mismatches = 0;
    endfunction

    function void set_gain(logic [mcfir_pkg::GAIN_W-1:0] g);
        gain = longint'(g);
    endfunction

    function bit busy();
        return pending.size() != 0;
    endfunction

    // Scale by the gain, round half up to Q1.15 and clip.
    function logic signed [mcfir_pkg::DATA_W-1:0] round_saturate(longint acc);
        longint v;
        longint q;
        v = acc * gain + (longint'(1) <<< (mcfir_pkg::FRAC_SHIFT - 1));
        q = v >>> mcfir_pkg::FRAC_SHIFT;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return q[mcfir_pkg::DATA_W-1:0];
    endfunction

    function void absorb_beat(chan_beat_t b);
        int         idx;
        int         hidx;
        longint     acc_re;
        longint     acc_im;
        rx_sample_t s;
        case (b.func)
            mcfir_pkg::FUNC_LOAD: begin
                idx = (int'(b.rx_sel) * NTX + int'(b.tx_sel)) * NTAP + int'(b.tap_sel);
                tap_r[idx] = longint'(b.tap_re);
                tap_i[idx] = longint'(b.tap_im);
            end
            mcfir_pkg::FUNC_CLEAR: begin
                foreach (hist_r[i]) begin
                    hist_r[i] = 0;
                    hist_i[i] = 0;
                end
            end
            mcfir_pkg::FUNC_SAMPLE: begin
                for (int t = 0; t < NTX; t++) begin
                    for (int l = NTAP - 1; l > 0; l--) begin
                        hist_r[t*NTAP+l] = hist_r[t*NTAP+l-1];
                        hist_i[t*NTAP+l] = hist_i[t*NTAP+l-1];
                    end
                    hist_r[t*NTAP] = (t == 0) ? longint'(b.samp0_re) :
                                     (t == 1) ? longint'(b.samp1_re) : 0;
                    hist_i[t*NTAP] = (t == 0) ? longint'(b.samp0_im) :
                                     (t == 1) ? longint'(b.samp1_im) : 0;
                end
                for (int r = 0; r < NRX; r++) begin
                    acc_re = 0;
                    acc_im = 0;
                    for (int t = 0; t < NTX; t++) begin
                        for (int l = 0; l < NTAP; l++) begin
                            idx    = (r * NTX + t) * NTAP + l;
                            hidx   = t * NTAP + l;
                            acc_re += tap_r[idx] * hist_r[hidx] - tap_i[idx] * hist_i[hidx];
                            acc_im += tap_r[idx] * hist_i[hidx] + tap_i[idx] * hist_r[hidx];
                        end
                    end
                    s.rx_index = r[0];
                    s.out_re   = round_saturate(acc_re);
                    s.out_im   = round_saturate(acc_im);
                    s.last     = (r == NRX - 1);
                    pending.push_back(s);
                end
            end
            default: ;
        endcase
    endfunction

    function void note_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: %s", what);
        end
    endfunction

    function void match_rx_sample(rx_sample_t got);
        rx_sample_t want;
        if (pending.size() == 0) begin
            note_mismatch($sformatf("unexpected result rx %0d re %0d im %0d last %0d",
                                    got.rx_index, got.out_re, got.out_im, got.last));
            return;
        end
        want = pending.pop_front();
        if (got.rx_index !== want.rx_index || got.out_re !== want.out_re ||
            got.out_im !== want.out_im || got.last !== want.last) begin
            note_mismatch($sformatf(
                "expected rx %0d re %0d im %0d last %0d, got rx %0d re %0d im %0d last %0d",
                want.rx_index, want.out_re, want.out_im, want.last,
                got.rx_index, got.out_re, got.out_im, got.last));
        end
    endfunction

    function void close_out();
        if (pending.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", pending.size()));
        end
    endfunction
endclass

module mimo_complex_fir_channel_tb;
    import mcfir_pkg::*;

    localparam int SETTLE_CYCLES = 60;     // longer than one sample beat when the output does not stall
    localparam int RANDOM_BEATS  = 1700;
    localparam int PHASE_COUNT   = 8;
    localparam int CHUNK_BEATS   = 53;     // beats between changes of idling pattern
    localparam int HEAVY_PCT     = 54;
    localparam int LIGHT_PCT     = 14;

    localparam logic [FUNC_W-1:0]        FUNC_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] Q15_MAX     = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] Q15_MIN     = 16'sh8000;
    localparam logic signed [DATA_W-1:0] Q15_HALF    = 16'sd16384;
    localparam logic signed [DATA_W-1:0] Q15_ZERO    = 16'sd0;
    localparam logic signed [DATA_W-1:0] Q15_LSB     = 16'sd1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // Every input starts at a known value; reset is held low from time zero.
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [GAIN_W-1:0]        i_cfg_wdata = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_ready;
    logic [FUNC_W-1:0]        i_func      = '0;
    logic                     i_rx_sel    = 1'b0;
    logic                     i_tx_sel    = 1'b0;
    logic [TAPS_SEL_W-1:0]    i_tap_sel   = '0;
    logic signed [DATA_W-1:0] i_tap_re    = '0;
    logic signed [DATA_W-1:0] i_tap_im    = '0;
    logic signed [DATA_W-1:0] i_samp0_re  = '0;
    logic signed [DATA_W-1:0] i_samp0_im  = '0;
    logic signed [DATA_W-1:0] i_samp1_re  = '0;
    logic signed [DATA_W-1:0] i_samp1_im  = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_rx_index;
    logic signed [DATA_W-1:0] o_out_re;
    logic signed [DATA_W-1:0] o_out_im;
    logic                     o_last;

    rx_sample_ledger ledger;
    int              sender_idle_pct    = 0;
    int              receiver_stall_pct = 0;

    mimo_complex_fir_channel DUT (.*);

    always #2 i_clk = ~i_clk;

    // Fail safe: a hung handshake must not run forever.
    initial begin
        #2000000;
        $display("mimo_complex_fir_channel verification failed");
        $finish;
    end

    // Receiver: sample the result beat before the edge settles, then pick the
    // next ready level. Check only beats taken on this edge.
    always @(posedge i_clk) begin
        rx_sample_t got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.rx_index = o_rx_index;
            got.out_re   = o_out_re;
            got.out_im   = o_out_im;
            got.last     = o_last;
            ledger.match_rx_sample(got);
        end
        i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Small magnitudes most often so that sums stay clear of saturation, with the
    // rails, zero and full-range values mixed in.
    function automatic logic signed [DATA_W-1:0] pick_q15();
        int v;
        case ($urandom_range(0, 9))
            0:          v = 32767;
            1:          v = -32768;
            2:          v = 0;
            3, 4, 5, 6: v = int'($urandom_range(0, 4095)) - 2048;
            default:    v = int'($urandom);
        endcase
        return v[DATA_W-1:0];
    endfunction

    function automatic chan_beat_t make_beat(
        input logic [FUNC_W-1:0]        func,
        input logic                     rx,
        input logic                     tx,
        input logic [TAPS_SEL_W-1:0]    tap,
        input logic signed [DATA_W-1:0] tr,
        input logic signed [DATA_W-1:0] ti,
        input logic signed [DATA_W-1:0] s0r,
        input logic signed [DATA_W-1:0] s0i,
        input logic signed [DATA_W-1:0] s1r,
        input logic signed [DATA_W-1:0] s1i
    );
        chan_beat_t b;
        b.func     = func;
        b.rx_sel   = rx;
        b.tx_sel   = tx;
        b.tap_sel  = tap;
        b.tap_re   = tr;
        b.tap_im   = ti;
        b.samp0_re = s0r;
        b.samp0_im = s0i;
        b.samp1_re = s1r;
        b.samp1_im = s1i;
        return b;
    endfunction

    // Mostly sample vectors, with tap reloads, history clears and the odd
    // unused code. Fields that the function ignores still carry noise.
    function automatic chan_beat_t random_beat();
        chan_beat_t b;
        int         roll;
        roll = int'($urandom_range(0, 99));
        b = make_beat(FUNC_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      3'($urandom_range(0, 7)), pick_q15(), pick_q15(),
                      pick_q15(), pick_q15(), pick_q15(), pick_q15());
        if (roll < 12) begin
            b.func = FUNC_LOAD;
        end else if (roll < 17) begin
            b.func = FUNC_CLEAR;
        end else if (roll < 20) begin
            b.func = FUNC_UNUSED;
        end
        return b;
    endfunction

    task automatic set_idle_mode(idle_mode_t m);
        case (m)
            IDLE_NONE: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct    = HEAVY_PCT;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = HEAVY_PCT;
            end
            default: begin
                sender_idle_pct    = LIGHT_PCT;
                receiver_stall_pct = LIGHT_PCT;
            end
        endcase
    endtask

    // Called just after a rising edge. Insert a random gap, present the beat,
    // hold it until ready is seen on an edge, then hand it to the ledger.
    // Valid stays high across back-to-back beats.
    task automatic send_beat(chan_beat_t b);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_func     <= b.func;
        i_rx_sel   <= b.rx_sel;
        i_tx_sel   <= b.tx_sel;
        i_tap_sel  <= b.tap_sel;
        i_tap_re   <= b.tap_re;
        i_tap_im   <= b.tap_im;
        i_samp0_re <= b.samp0_re;
        i_samp0_im <= b.samp0_im;
        i_samp1_re <= b.samp1_re;
        i_samp1_im <= b.samp1_im;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        ledger.absorb_beat(b);
    endtask

    // Drop valid, wait for every outstanding result, then let a trailing
    // load or clear finish before anything touches the gain register.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (ledger.busy()) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [GAIN_W-1:0] g);
        i_cfg_wdata <= g;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ledger.set_gain(g);
    endtask

    initial begin
        chan_beat_t        b;
        int                sent;
        logic [GAIN_W-1:0] gains[PHASE_COUNT];

        ledger = new();
        // Phase zero and phase seven run on the reset gain; the rest cover the
        // rails, the smallest step, just below unity and two random settings.
        gains[0] = GAIN_RESET;
        gains[1] = 16'h0000;
        gains[2] = 16'hffff;
        gains[3] = 16'h0001;
        gains[4] = 16'h7fff;
        gains[5] = 16'($urandom_range(0, 32768));
        gains[6] = 16'($urandom);
        gains[7] = GAIN_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idle_mode(IDLE_NONE);

        // Fill every tap first: an unwritten tap must never be read.
        for (int r = 0; r < NUM_RX_DEF; r++) begin
            for (int t = 0; t < NUM_TX_DEF; t++) begin
                for (int l = 0; l < TAPS_DEF; l++) begin
                    send_beat(make_beat(FUNC_LOAD, 1'(r), 1'(t), 3'(l), pick_q15(),
                                        pick_q15(), pick_q15(), pick_q15(),
                                        pick_q15(), pick_q15()));
                end
            end
        end

        // Directed: a single live product per receive antenna on the first sample so that the rounding
        // tie lands exactly on a half step, both signs.
        send_beat(make_beat(FUNC_CLEAR, 1'b0, 1'b0, 3'd0, Q15_ZERO, Q15_ZERO,
                            Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO));
        send_beat(make_beat(FUNC_LOAD, 1'b0, 1'b0, 3'd0, Q15_LSB, Q15_ZERO,
                            Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO));
        send_beat(make_beat(FUNC_LOAD, 1'b0, 1'b1, 3'd0, Q15_ZERO, Q15_ZERO,
                            Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO));
        send_beat(make_beat(FUNC_LOAD, 1'b1, 1'b0, 3'd0, Q15_ZERO, Q15_LSB,
                            Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO));
        send_beat(make_beat(FUNC_LOAD, 1'b1, 1'b1, 3'd0, Q15_MIN, Q15_MIN,
                            Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO));
        send_beat(make_beat(FUNC_SAMPLE, 1'b0, 1'b0, 3'd0, Q15_ZERO, Q15_ZERO,
                            Q15_HALF, -Q15_HALF, Q15_ZERO, Q15_ZERO));
        send_beat(make_beat(FUNC_SAMPLE, 1'b1, 1'b1, 3'd7, Q15_MAX, Q15_MAX,
                            -Q15_HALF, Q15_HALF, Q15_MAX, Q15_MIN));
        // Rails on every sample field: drive the sums into saturation.
        send_beat(make_beat(FUNC_SAMPLE, 1'b0, 1'b0, 3'd0, Q15_ZERO, Q15_ZERO,
                            Q15_MAX, Q15_MAX, Q15_MAX, Q15_MAX));
        send_beat(make_beat(FUNC_SAMPLE, 1'b0, 1'b0, 3'd0, Q15_ZERO, Q15_ZERO,
                            Q15_MIN, Q15_MIN, Q15_MIN, Q15_MIN));
        // Unused function code: no result, no state change.
        send_beat(make_beat(FUNC_UNUSED, 1'b1, 1'b1, 3'd7, pick_q15(), pick_q15(),
                            pick_q15(), pick_q15(), pick_q15(), pick_q15()));
        send_beat(make_beat(FUNC_SAMPLE, 1'b0, 1'b0, 3'd0, Q15_ZERO, Q15_ZERO,
                            Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO));
        send_beat(make_beat(FUNC_CLEAR, 1'b1, 1'b1, 3'd7, Q15_MAX, Q15_MIN,
                            Q15_MAX, Q15_MIN, Q15_MAX, Q15_MIN));
        send_beat(make_beat(FUNC_SAMPLE, 1'b0, 1'b0, 3'd0, Q15_ZERO, Q15_ZERO,
                            Q15_MAX, Q15_MAX, Q15_MAX, Q15_MAX));
        // Rail taps at the deepest delay, then walk a sample down the line.
        send_beat(make_beat(FUNC_LOAD, 1'b1, 1'b1, 3'd7, Q15_MAX, Q15_MAX,
                            Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO));
        send_beat(make_beat(FUNC_LOAD, 1'b0, 1'b0, 3'd7, Q15_MIN, Q15_MAX,
                            Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO));
        for (int k = 0; k < TAPS_DEF; k++) begin
            send_beat(make_beat(FUNC_SAMPLE, 1'b0, 1'b0, 3'd0, Q15_ZERO, Q15_ZERO,
                                (k % 2 == 0) ? Q15_MIN : Q15_MAX, Q15_MAX,
                                Q15_MIN, (k % 2 == 0) ? Q15_MAX : Q15_MIN));
        end
        send_beat(make_beat(FUNC_CLEAR, 1'b0, 1'b0, 3'd0, Q15_ZERO, Q15_ZERO,
                            Q15_ZERO, Q15_ZERO, Q15_ZERO, Q15_ZERO));
        send_beat(make_beat(FUNC_SAMPLE, 1'b0, 1'b0, 3'd0, Q15_ZERO, Q15_ZERO,
                            16'sd3, -16'sd5, 16'sd7, -16'sd11));

        // Random phases, one gain each. Rotate the idling pattern every chunk
        // so gaps and stalls fall on every part of the accumulate sequence.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase != 0) begin
                drain();
                write_gain(gains[phase]);
            end
            sent = 0;
            while (sent < RANDOM_BEATS / PHASE_COUNT) begin
                if (sent % CHUNK_BEATS == 0) begin
                    set_idle_mode(idle_mode_t'((sent / CHUNK_BEATS + phase) % 4));
                end
                b = random_beat();
                send_beat(b);
                if (b.func != FUNC_UNUSED) begin
                    sent++;
                end
            end
        end

        drain();
        ledger.close_out();
        if (ledger.mismatches == 0) begin
            $display("mimo_complex_fir_channel verification clean");
        end else begin
            $display("mimo_complex_fir_channel verification failed");
        end
        $finish;
    end
endmodule
